// ===== hw/rtl/twp_pkg.sv =====
package twp_pkg;

    // Default table depth
    localparam int TWP_DEPTH_DEF = 64;

    // Field and datapath widths
    localparam int TIME_W  = 32;
    localparam int RATIO_W = 16;
    localparam int WT_W    = 17;  // blend weight, b +/- 16384
    localparam int PROD_W  = 49;  // time * weight
    localparam int POS_W   = 50;  // blended position
    localparam int DIFF_W  = 51;  // difference of two positions
    localparam int TRI_W   = 53;  // divider partial remainder, below 3*den
    localparam int MAG_W   = 33;  // magnitude of a coordinate span
    localparam int SHIFT_W = 36;  // tail offset after the /32768
    localparam int QS_SH   = 15;  // query scaled by 32768

    // Weight offset: 0.5 in Q15
    localparam logic signed [WT_W-1:0] WT_HALF = 17'sd16384;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        CMD_HOLD   = 4'b0001,
        CMD_INSERT = 4'b0010,
        CMD_DELETE = 4'b0100,
        CMD_ROTATE = 4'b1000
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                 cmd;
        logic signed [TIME_W-1:0]  src;
        logic signed [TIME_W-1:0]  dst;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/twp_if.sv =====
interface twp_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] src_time;
    logic signed [31:0] dst_time;
    logic signed [31:0] query_time;
    logic signed [15:0] blend_ratio;

    modport source (output valid, op, src_time, dst_time, query_time, blend_ratio,
                    input ready);
    modport sink   (input valid, op, src_time, dst_time, query_time, blend_ratio,
                    output ready);
endinterface

interface twp_rsp_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic signed [31:0] out_src;
    logic signed [31:0] out_dst;

    modport source (output valid, ok, out_src, out_dst, input ready);
    modport sink   (input valid, ok, out_src, out_dst, output ready);
endinterface

// ===== hw/rtl/twp_cell.sv =====
module twp_cell #(
    parameter int IDX_W = 6,
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  logic                              clk,
    input  twp_pkg::cell_ctl_t                ctl,
    input  logic [CNT_W-1:0]                  count,
    input  logic [IDX_W-1:0]                  del_k,
    input  logic signed [twp_pkg::TIME_W-1:0] prev_src,
    input  logic signed [twp_pkg::TIME_W-1:0] prev_dst,
    input  logic                              prev_lt,
    input  logic signed [twp_pkg::TIME_W-1:0] next_src,
    input  logic signed [twp_pkg::TIME_W-1:0] next_dst,
    output logic signed [twp_pkg::TIME_W-1:0] src,
    output logic signed [twp_pkg::TIME_W-1:0] dst,
    output logic                              lt,
    output logic                              refuse
);
    import twp_pkg::*;

    localparam logic [CNT_W-1:0] IDX_CNT = CNT_W'(IDX);
    localparam logic [IDX_W-1:0] IDX_POS = IDX_W'(IDX);

    logic signed [TIME_W-1:0] src_reg, src_next;
    logic signed [TIME_W-1:0] dst_reg, dst_next;
    logic                     first;

    // Unused slots count as greater, so lt is monotone along the row
    assign lt     = (IDX_CNT >= count) || (ctl.src < src_reg);
    assign first  = lt && !prev_lt;
    assign refuse = first && (IDX_CNT < count) && !(ctl.dst < dst_reg);

    // Slot update per command
    always_comb
    begin
        src_next = src_reg;
        dst_next = dst_reg;
        case (ctl.cmd)
            CMD_INSERT:
            begin
                if (prev_lt)
                begin
                    src_next = prev_src;
                    dst_next = prev_dst;
                end
                else if (lt)
                begin
                    src_next = ctl.src;
                    dst_next = ctl.dst;
                end
            end
            CMD_DELETE:
            begin
                if (IDX_POS >= del_k)
                begin
                    src_next = next_src;
                    dst_next = next_dst;
                end
            end
            CMD_ROTATE:
            begin
                src_next = next_src;
                dst_next = next_dst;
            end
            default:
            begin
                src_next = src_reg;
                dst_next = dst_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        dst_reg <= dst_next;
    end

    assign src = src_reg;
    assign dst = dst_reg;

endmodule

// ===== hw/rtl/twp_div.sv =====
module twp_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [twp_pkg::MAG_W-1:0]    mag,
    input  logic [twp_pkg::DIFF_W-1:0]   num,
    input  logic [twp_pkg::DIFF_W-1:0]   den,
    output logic                         busy,
    output logic [twp_pkg::MAG_W-1:0]    quot
);
    import twp_pkg::*;

    localparam int STEP_W = $clog2(MAG_W);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [MAG_W-1:0]  mag_reg;
    logic [DIFF_W-1:0] num_reg;
    logic [DIFF_W-1:0] den_reg;
    logic [DIFF_W-1:0] rem_reg;
    logic [MAG_W-1:0]  quot_reg;
    logic [TRI_W-1:0]  t;
    logic [TRI_W-1:0]  d1;
    logic [TRI_W-1:0]  d2;
    logic [DIFF_W-1:0] rem_step;
    logic [MAG_W-1:0]  quot_step;

    // floor(mag*num/den), one bit of mag per cycle; num <= den keeps t < 3*den
    assign t  = TRI_W'({rem_reg, 1'b0}) + (mag_reg[MAG_W-1] ? TRI_W'(num_reg) : '0);
    assign d1 = TRI_W'(den_reg);
    assign d2 = TRI_W'({den_reg, 1'b0});

    always_comb
    begin
        if (t >= d2)
        begin
            rem_step  = DIFF_W'(t - d2);
            quot_step = MAG_W'({quot_reg, 1'b0} + 2'd2);
        end
        else if (t >= d1)
        begin
            rem_step  = DIFF_W'(t - d1);
            quot_step = MAG_W'({quot_reg, 1'b0} + 2'd1);
        end
        else
        begin
            rem_step  = DIFF_W'(t);
            quot_step = MAG_W'({quot_reg, 1'b0});
        end
    end

    // Step control
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(MAG_W - 1);
        end
        else if (busy_reg)
        begin
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg  <= mag;
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg  <= {mag_reg[MAG_W-2:0], 1'b0};
            rem_reg  <= rem_step;
            quot_reg <= quot_step;
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

// ===== hw/rtl/time_warp_breakpoint_map.sv =====
// Time-warp breakpoint map.
// req carries one item: op (insert, remove, lookup), a pair src_time/dst_time
// and, for lookup, query_time and blend_ratio. rsp returns one item per
// request: ok, and for lookup the interpolated out_src/out_dst.
// The pairs sit in a row of TABLE_DEPTH cells kept sorted by source time.
// Insert: all cells compare in parallel and the row is updated in the S_INS
// state. Remove and lookup rotate the whole row once past a shared head
// through a two-stage multiply/add pipe; remove then shifts the row in
// S_DEL, lookup runs two 33-step serial dividers (one per coordinate) for
// a segment hit or the S_TAIL and S_SAT states for the tail case.
// One item is worked on at a time; req.ready is high only when idle.
// The result sits in an output register; while rsp stalls the next item may
// still be accepted and processed, and a second result waits inside.
// Reset empties the table (count zero) and drops any held result; the cell
// contents are not cleared.
module time_warp_breakpoint_map #(
    parameter int TABLE_DEPTH = twp_pkg::TWP_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    twp_req_if.sink   req,
    twp_rsp_if.source rsp
);
    import twp_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_INS   = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_DRAIN = 9'b000001000,
        S_DEL   = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_TAIL  = 9'b001000000,
        S_SAT   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              a_v_reg, b_v_reg;
    logic              rm_found_reg, lk_found_reg;
    logic              rsp_v_reg, rsp_v_next;

    // Latched item
    op_t                       op_reg;
    logic signed [TIME_W-1:0]  s_reg, d_reg, q_reg;
    logic signed [WT_W-1:0]    ws_reg, wd_reg;

    // Row wiring
    cell_ctl_t                 ctl;
    logic [IDX_W-1:0]          rm_k_reg;
    logic signed [TIME_W-1:0]  cell_src [TABLE_DEPTH];
    logic signed [TIME_W-1:0]  cell_dst [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]    cell_lt;
    logic [TABLE_DEPTH-1:0]    cell_refuse;
    logic                      ins_ok;

    // Scan pipe
    logic [IDX_W-1:0]          a_j_reg, b_j_reg;
    logic signed [TIME_W-1:0]  a_src_reg, a_dst_reg, b_src_reg, b_dst_reg;
    logic signed [PROD_W-1:0]  a_ps_reg, a_pd_reg;
    logic signed [POS_W-1:0]   b_p_reg;
    logic signed [POS_W-1:0]   prev_p_reg;
    logic signed [TIME_W-1:0]  prev_src_reg, prev_dst_reg;
    logic signed [POS_W-1:0]   q_big;
    logic                      b_in;

    // Segment and tail captures
    logic signed [TIME_W-1:0]  l_src_reg, l_dst_reg, r_src_reg, r_dst_reg;
    logic [DIFF_W-1:0]         lk_n_reg, lk_den_reg;
    logic signed [POS_W-1:0]   last_p_reg;
    logic signed [TIME_W-1:0]  last_src_reg, last_dst_reg;
    logic signed [SHIFT_W-1:0] diff_reg;

    // Divider hookup
    logic                      div_start, div_busy_s, div_busy_d;
    logic signed [MAG_W-1:0]   span_src, span_dst;
    logic [MAG_W-1:0]          mag_src, mag_dst, m_src, m_dst;
    logic                      neg_src_reg, neg_dst_reg;

    // Result
    logic                      res_ok_reg;
    logic signed [TIME_W-1:0]  res_src_reg, res_dst_reg;
    logic                      rsp_ok_reg;
    logic signed [TIME_W-1:0]  rsp_src_reg, rsp_dst_reg;

    logic                      in_acc;
    logic                      rsp_load;

    assign req.ready = (state_reg == S_IDLE);
    assign in_acc    = req.valid && req.ready;
    assign rsp_load  = (state_reg == S_DONE) && (!rsp_v_reg || rsp.ready);

    // Row of cells
    assign ins_ok = (count_reg < DEPTH_CNT) && !(|cell_refuse);

    always_comb
    begin
        ctl.src = s_reg;
        ctl.dst = d_reg;
        ctl.cmd = CMD_HOLD;
        if (state_reg == S_INS && ins_ok)
        begin
            ctl.cmd = CMD_INSERT;
        end
        else if (state_reg == S_SCAN)
        begin
            ctl.cmd = CMD_ROTATE;
        end
        else if (state_reg == S_DEL)
        begin
            ctl.cmd = CMD_DELETE;
        end
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        localparam int PI = (i == 0) ? 0 : i - 1;
        localparam int NI = (i == TABLE_DEPTH - 1) ? 0 : i + 1;
        twp_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .count    (count_reg),
            .del_k    (rm_k_reg),
            .prev_src (cell_src[PI]),
            .prev_dst (cell_dst[PI]),
            .prev_lt  ((i == 0) ? 1'b0 : cell_lt[PI]),
            .next_src (cell_src[NI]),
            .next_dst (cell_dst[NI]),
            .src      (cell_src[i]),
            .dst      (cell_dst[i]),
            .lt       (cell_lt[i]),
            .refuse   (cell_refuse[i])
        );
    end

    // Blended position pipe behind the head cell
    assign q_big = POS_W'(q_reg) <<< QS_SH;
    assign b_in  = b_v_reg && (CNT_W'(b_j_reg) < count_reg);

    always_ff @(posedge clk)
    begin
        a_j_reg   <= cnt_reg;
        a_src_reg <= cell_src[0];
        a_dst_reg <= cell_dst[0];
        a_ps_reg  <= PROD_W'(cell_src[0]) * PROD_W'(ws_reg);
        a_pd_reg  <= PROD_W'(cell_dst[0]) * PROD_W'(wd_reg);
        b_j_reg   <= a_j_reg;
        b_src_reg <= a_src_reg;
        b_dst_reg <= a_dst_reg;
        b_p_reg   <= POS_W'(a_ps_reg) + POS_W'(a_pd_reg);
    end

    // Scan evaluation on stage B
    always_ff @(posedge clk)
    begin
        if (b_v_reg)
        begin
            prev_p_reg   <= b_p_reg;
            prev_src_reg <= b_src_reg;
            prev_dst_reg <= b_dst_reg;
        end
        if (b_in && b_j_reg != '0 && !lk_found_reg &&
            prev_p_reg < q_big && b_p_reg >= q_big)
        begin
            l_src_reg  <= prev_src_reg;
            l_dst_reg  <= prev_dst_reg;
            r_src_reg  <= b_src_reg;
            r_dst_reg  <= b_dst_reg;
            lk_n_reg   <= DIFF_W'(DIFF_W'(q_big) - DIFF_W'(prev_p_reg));
            lk_den_reg <= DIFF_W'(DIFF_W'(b_p_reg) - DIFF_W'(prev_p_reg));
        end
        if (b_in && CNT_W'(b_j_reg) == count_reg - 1'b1)
        begin
            last_p_reg   <= b_p_reg;
            last_src_reg <= b_src_reg;
            last_dst_reg <= b_dst_reg;
        end
        if (b_in && !rm_found_reg && b_src_reg == s_reg && b_dst_reg == d_reg)
        begin
            rm_k_reg <= b_j_reg;
        end
    end

    // Span magnitudes for the dividers
    assign span_src = MAG_W'(r_src_reg) - MAG_W'(l_src_reg);
    assign span_dst = MAG_W'(r_dst_reg) - MAG_W'(l_dst_reg);
    assign mag_src  = span_src[MAG_W-1] ? MAG_W'(-span_src) : MAG_W'(span_src);
    assign mag_dst  = span_dst[MAG_W-1] ? MAG_W'(-span_dst) : MAG_W'(span_dst);

    twp_div u_div_src (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (mag_src),
        .num   (lk_n_reg),
        .den   (lk_den_reg),
        .busy  (div_busy_s),
        .quot  (m_src)
    );

    twp_div u_div_dst (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (mag_dst),
        .num   (lk_n_reg),
        .den   (lk_den_reg),
        .busy  (div_busy_d),
        .quot  (m_dst)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cnt_next   = cnt_reg;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_acc)
                begin
                    case (op_t'(req.op))
                        OP_INSERT: state_next = S_INS;
                        OP_REMOVE: state_next = S_SCAN;
                        OP_LOOKUP: state_next = S_SCAN;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_INS:
            begin
                if (ins_ok)
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!a_v_reg && !b_v_reg)
                begin
                    if (op_reg == OP_REMOVE)
                    begin
                        state_next = rm_found_reg ? S_DEL : S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else if (lk_found_reg)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_DEL:
            begin
                count_next = count_reg - 1'b1;
                state_next = S_DONE;
            end
            S_DIV:
            begin
                if (!div_busy_s && !div_busy_d)
                begin
                    state_next = S_DONE;
                end
            end
            S_TAIL:
            begin
                state_next = S_SAT;
            end
            S_SAT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_v_next = (rsp_v_reg && !rsp.ready) || rsp_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cnt_reg      <= '0;
            a_v_reg      <= 1'b0;
            b_v_reg      <= 1'b0;
            rm_found_reg <= 1'b0;
            lk_found_reg <= 1'b0;
            rsp_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cnt_reg   <= cnt_next;
            a_v_reg   <= (state_reg == S_SCAN);
            b_v_reg   <= a_v_reg;
            rsp_v_reg <= rsp_v_next;
            if (in_acc)
            begin
                rm_found_reg <= 1'b0;
                lk_found_reg <= 1'b0;
            end
            else
            begin
                if (b_in && !rm_found_reg && b_src_reg == s_reg && b_dst_reg == d_reg)
                begin
                    rm_found_reg <= 1'b1;
                end
                if (b_in && b_j_reg != '0 && prev_p_reg < q_big && b_p_reg >= q_big)
                begin
                    lk_found_reg <= 1'b1;
                end
            end
        end
    end

    // Item capture and result formation
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg      <= op_t'(req.op);
            s_reg       <= req.src_time;
            d_reg       <= req.dst_time;
            q_reg       <= req.query_time;
            ws_reg      <= WT_W'(req.blend_ratio) + WT_HALF;
            wd_reg      <= WT_HALF - WT_W'(req.blend_ratio);
            res_ok_reg  <= 1'b0;
            res_src_reg <= '0;
            res_dst_reg <= '0;
        end
        case (state_reg)
            S_INS:
            begin
                res_ok_reg <= ins_ok;
            end
            S_DRAIN:
            begin
                neg_src_reg <= span_src[MAG_W-1];
                neg_dst_reg <= span_dst[MAG_W-1];
                if (op_reg == OP_REMOVE)
                begin
                    res_ok_reg <= rm_found_reg;
                end
                else
                begin
                    res_ok_reg  <= 1'b1;
                    res_src_reg <= q_reg;
                    res_dst_reg <= q_reg;
                end
            end
            S_DIV:
            begin
                res_src_reg <= neg_src_reg ? l_src_reg - TIME_W'(m_src)
                                           : l_src_reg + TIME_W'(m_src);
                res_dst_reg <= neg_dst_reg ? l_dst_reg - TIME_W'(m_dst)
                                           : l_dst_reg + TIME_W'(m_dst);
            end
            S_TAIL:
            begin
                diff_reg <= tail_shift(DIFF_W'(q_big) - DIFF_W'(last_p_reg));
            end
            S_SAT:
            begin
                res_src_reg <= sat_time(SHIFT_W'(last_src_reg) + diff_reg);
                res_dst_reg <= sat_time(SHIFT_W'(last_dst_reg) + diff_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Divide by 32768, truncating toward zero
    function automatic logic signed [SHIFT_W-1:0] tail_shift(
        input logic signed [DIFF_W-1:0] x
    );
        logic signed [DIFF_W-1:0] fl;
        fl = x >>> QS_SH;
        if (x[DIFF_W-1] && (x[QS_SH-1:0] != '0))
        begin
            fl = fl + 1'b1;
        end
        return SHIFT_W'(fl);
    endfunction

    // Saturate to the 32-bit time range
    function automatic logic signed [TIME_W-1:0] sat_time(
        input logic signed [SHIFT_W-1:0] x
    );
        logic signed [SHIFT_W-1:0] hi;
        logic signed [SHIFT_W-1:0] lo;
        hi = SHIFT_W'({1'b0, {(TIME_W-1){1'b1}}});
        lo = -hi - 1'b1;
        if (x > hi)
        begin
            return TIME_W'(hi);
        end
        else if (x < lo)
        begin
            return TIME_W'(lo);
        end
        return TIME_W'(x);
    endfunction

    // Output register
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_ok_reg  <= res_ok_reg;
            rsp_src_reg <= res_src_reg;
            rsp_dst_reg <= res_dst_reg;
        end
    end

    assign rsp.valid   = rsp_v_reg;
    assign rsp.ok      = rsp_ok_reg;
    assign rsp.out_src = rsp_src_reg;
    assign rsp.out_dst = rsp_dst_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count beyond table depth");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS && ins_ok) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the table");

    a_del_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEL) |-> rm_found_reg && count_reg != '0)
        else $error("delete without a matching entry");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy_s && !div_busy_d && lk_den_reg != '0)
        else $error("divider started while busy or with zero span");

endmodule

// ===== test/tb.sv =====
module tb;
    import twp_pkg::*;

    localparam int DEPTH      = TWP_DEPTH_DEF;
    localparam int WDOG_LIMIT = 20000;
    localparam int HOLD_CYC   = 400;
    localparam int TAIL_CYC   = 200;

    typedef struct {
        logic               ok;
        logic signed [31:0] src;
        logic signed [31:0] dst;
    } result_t;

    logic clk;
    logic rst_n;

    twp_req_if req_ch();
    twp_rsp_if rsp_ch();

    time_warp_breakpoint_map #(.TABLE_DEPTH(DEPTH)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the breakpoint table
    longint  map_src [DEPTH];
    longint  map_dst [DEPTH];
    int      map_count;

    result_t pending_results [$];
    int      fail_count;
    int      burst_left;
    bit      hold_rsp;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] clamp32(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    // l + (r-l)*num/den, magnitude truncated
    function automatic longint seg_interp(longint l, longint r, longint num, longint den);
        longint     span;
        logic [127:0] mag;
        logic [127:0] frac;
        longint     m;
        span = r - l;
        mag  = (span < 0) ? 128'(-span) : 128'(span);
        frac = (mag * 128'(num)) / 128'(den);
        m    = longint'(frac[63:0]);
        return (span < 0) ? l - m : l + m;
    endfunction

    function automatic result_t predict_map(op_t op, logic signed [31:0] s,
                                            logic signed [31:0] d,
                                            logic signed [31:0] q,
                                            logic signed [15:0] r);
        result_t res;
        int      k;
        int      i;
        longint  ws;
        longint  wd;
        longint  qs;
        longint  p1;
        longint  p2;
        longint  pl;
        longint  shift;
        bit      hit;
        res.ok = 1'b0;
        res.src = '0;
        res.dst = '0;
        hit = 1'b0;
        case (op)
            OP_INSERT:
            begin
                if (map_count < DEPTH)
                begin
                    k = 0;
                    while (k < map_count && !(longint'(s) < map_src[k]))
                        k++;
                    if (k == map_count || longint'(d) < map_dst[k])
                    begin
                        for (i = map_count; i > k; i--)
                        begin
                            map_src[i] = map_src[i-1];
                            map_dst[i] = map_dst[i-1];
                        end
                        map_src[k] = s;
                        map_dst[k] = d;
                        map_count++;
                        res.ok = 1'b1;
                    end
                end
            end
            OP_REMOVE:
            begin
                k = 0;
                while (k < map_count && !(map_src[k] == s && map_dst[k] == d))
                    k++;
                if (k < map_count)
                begin
                    for (i = k; i + 1 < map_count; i++)
                    begin
                        map_src[i] = map_src[i+1];
                        map_dst[i] = map_dst[i+1];
                    end
                    map_count--;
                    res.ok = 1'b1;
                end
            end
            OP_LOOKUP:
            begin
                res.ok = 1'b1;
                ws = longint'(r) + 16384;
                wd = 16384 - longint'(r);
                qs = longint'(q) * 32768;
                if (map_count == 0)
                begin
                    res.src = q;
                    res.dst = q;
                end
                else
                begin
                    for (i = 1; i < map_count && !hit; i++)
                    begin
                        p1 = map_src[i-1] * ws + map_dst[i-1] * wd;
                        p2 = map_src[i] * ws + map_dst[i] * wd;
                        if (p1 < qs && p2 >= qs)
                        begin
                            res.src = clamp32(seg_interp(map_src[i-1], map_src[i], qs - p1, p2 - p1));
                            res.dst = clamp32(seg_interp(map_dst[i-1], map_dst[i], qs - p1, p2 - p1));
                            hit = 1'b1;
                        end
                    end
                    // no segment hit: shift the last pair
                    if (!hit)
                    begin
                        pl = map_src[map_count-1] * ws + map_dst[map_count-1] * wd;
                        shift = (qs - pl) / 32768;
                        res.src = clamp32(map_src[map_count-1] + shift);
                        res.dst = clamp32(map_dst[map_count-1] + shift);
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_item(op_t op, logic signed [31:0] s, logic signed [31:0] d,
                             logic signed [31:0] q, logic signed [15:0] r);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.src_time    <= s;
        req_ch.dst_time    <= d;
        req_ch.query_time  <= q;
        req_ch.blend_ratio <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_map(op, s, d, q, r));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_time();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 4000)) - 2000;
            2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 50)
                                                 : 32'sh80000000 + $urandom_range(0, 50);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_ratio();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 32768)) - 16384;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_item(OP_LOOKUP, 0, 0, 32'sh7fffffff, 16'sd0);
        send_item(OP_LOOKUP, 0, 0, 32'sh80000000, 16'sd16384);
        send_item(OP_NONE, 32'sd5, 32'sd5, 32'sd5, 16'sd5);
        send_item(OP_REMOVE, 32'sd1, 32'sd1, 0, 0);
        send_item(OP_INSERT, 32'sh80000000, 32'sh80000000, 0, 0);
        // single entry: tail case
        send_item(OP_LOOKUP, 0, 0, 32'sh7fffffff, 16'sd0);
        send_item(OP_INSERT, 32'sh7fffffff, 32'sh7fffffff, 0, 0);
        send_item(OP_INSERT, 32'sd0, 32'sd256, 0, 0);
        // destination not below the next entry: refused
        send_item(OP_INSERT, 32'sd100, 32'sh7fffffff, 0, 0);
        send_item(OP_INSERT, 32'sd0, 32'sd128, 0, 0);
        send_item(OP_LOOKUP, 0, 0, 32'sd100, 16'sd0);
        send_item(OP_LOOKUP, 0, 0, 32'sd100, 16'sd16384);
        send_item(OP_LOOKUP, 0, 0, 32'sd100, -16'sd16384);
        send_item(OP_LOOKUP, 0, 0, -32'sd1000, 16'sh8000);
        send_item(OP_LOOKUP, 0, 0, 32'sd1000, 16'sh7fff);
        send_item(OP_LOOKUP, 0, 0, 32'sh80000000, 16'sd0);
        send_item(OP_REMOVE, 32'sd0, 32'sd999, 0, 0);
        send_item(OP_REMOVE, 32'sd0, 32'sd256, 0, 0);
        send_item(OP_REMOVE, 32'sh80000000, 32'sh80000000, 0, 0);
        send_item(OP_REMOVE, 32'sh7fffffff, 32'sh7fffffff, 0, 0);
        send_item(OP_REMOVE, 32'sd0, 32'sd128, 0, 0);
        send_item(OP_LOOKUP, 0, 0, 32'sd77, 16'sd300);
    endtask

    // fill to capacity, one more is refused, then empty again
    task automatic test_table_full();
        for (int i = 0; i <= DEPTH; i++)
            send_item(OP_INSERT, i * 1000, i * 700, 0, 0);
        send_item(OP_LOOKUP, 0, 0, 32'sd20000, 16'sd0);
        for (int i = DEPTH - 1; i >= 0; i--)
            send_item(OP_REMOVE, i * 1000, i * 700, 0, 0);
    endtask

    // receiver stops for a long stretch while requests keep coming
    task automatic test_backpressure();
        hold_rsp = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(OP_INSERT, i * 64, i * 64, 0, 0);
        wait_drained();
        hold_rsp = 1'b0;
        for (int i = 0; i < 12; i++)
            send_item(OP_REMOVE, i * 64, i * 64, 0, 0);
        wait_drained();
    endtask

    task automatic test_random(int n_items);
        int     pick;
        int     j;
        longint t;
        logic signed [31:0] s;
        logic signed [31:0] d;
        logic signed [31:0] q;
        logic signed [15:0] r;
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(0, 99);
            if (map_count > DEPTH - 8 && pick < 40)
                pick = 40;
            s = rand_time();
            d = rand_time();
            q = rand_time();
            r = rand_ratio();
            if (pick < 40)
            begin
                // mostly pairs that fit below the next destination
                j = 0;
                while (j < map_count && !(longint'(s) < map_src[j]))
                    j++;
                if (j < map_count && pick < 34)
                begin
                    t = map_dst[j] - $urandom_range(1, 3000);
                    d = clamp32(t);
                end
                send_item(OP_INSERT, s, d, q, r);
            end
            else if (pick < 62)
            begin
                if (map_count > 0 && pick < 56)
                begin
                    j = $urandom_range(0, map_count - 1);
                    s = map_src[j];
                    d = map_dst[j];
                end
                send_item(OP_REMOVE, s, d, q, r);
            end
            else if (pick < 97)
            begin
                if (map_count > 0 && pick < 88)
                begin
                    j = $urandom_range(0, map_count - 1);
                    if ($urandom_range(0, 3) != 0)
                        r = $signed($urandom_range(0, 32768)) - 16384;
                    t = (map_src[j] * (longint'(r) + 16384)
                         + map_dst[j] * (16384 - longint'(r))) / 32768;
                    q = clamp32(t + $signed($urandom_range(0, 400)) - 200);
                end
                send_item(OP_LOOKUP, s, d, q, r);
            end
            else
                send_item(OP_NONE, s, d, q, r);
        end
    endtask

    // ------------------------------------------------------------------
    // response side: stall pattern and checking
    // ------------------------------------------------------------------
    int stall_phase;
    int hold_cnt;

    // one long hold per run, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_phase  <= 0;
            hold_cnt     <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (hold_rsp && hold_cnt < HOLD_CYC)
            begin
                hold_cnt     <= hold_cnt + 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case ((stall_phase >> 7) % 3)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 1) == 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result ok=%0b src=%0d dst=%0d", $time,
                         rsp_ch.ok, rsp_ch.out_src, rsp_ch.out_dst);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.ok !== want.ok)
                begin
                    $display("%0t: ok expected %0b actual %0b", $time, want.ok, rsp_ch.ok);
                    fail_count++;
                end
                if (rsp_ch.out_src !== want.src)
                begin
                    $display("%0t: out_src expected %0d actual %0d", $time,
                             want.src, rsp_ch.out_src);
                    fail_count++;
                end
                if (rsp_ch.out_dst !== want.dst)
                begin
                    $display("%0t: out_dst expected %0d actual %0d", $time,
                             want.dst, rsp_ch.out_dst);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_NONE;
        req_ch.src_time    = '0;
        req_ch.dst_time    = '0;
        req_ch.query_time  = '0;
        req_ch.blend_ratio = '0;
        map_count   = 0;
        fail_count  = 0;
        burst_left  = 0;
        hold_rsp    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        test_backpressure();
        test_random(600);
        wait_drained();
        test_random(600);

        wait_drained();
        repeat (TAIL_CYC) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
